// ===== src/bcrz_pkg.sv =====
package bcrz_pkg;

  localparam int unsigned MAX_BUCKETS_DEF = 64;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  localparam logic [31:0] BUCKET_LEN_RST = 32'd100000000;
  localparam logic [39:0] WINDOW_LEN_RST = 40'd1000000000;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 40;

  typedef enum logic [0:0] {
    REG_BUCKET_LEN = 1'b0,
    REG_WINDOW_LEN = 1'b1
  } bcrz_reg_t;

  localparam logic [1:0] SIDE_BID = 2'd0;
  localparam logic [1:0] SIDE_ASK = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPEND,
    ST_COUNT,
    ST_WREQ,
    ST_WDATA,
    ST_WACC,
    ST_WEND,
    ST_SCORE,
    ST_OUT
  } bcrz_st_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL,
    SC_PREP,
    SC_SQRT,
    SC_DIV
  } bcrz_sc_st_t;

  localparam logic [31:0] Z_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Z_MIN = 32'h8000_0000;

endpackage

// ===== src/bcrz_mem.sv =====
module bcrz_mem #(
  parameter int unsigned DEPTH = bcrz_pkg::MAX_BUCKETS_DEF,
  parameter int unsigned WIDTH = 64 + 2 * bcrz_pkg::COUNT_BITS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bcrz_score.sv =====
// Score unit for one side: serial n*q - s*s, bit-serial square root,
// restoring division, then saturation to Q16.16.
module bcrz_score #(
  parameter int unsigned CB = bcrz_pkg::COUNT_BITS_DEF,
  parameter int unsigned NW = $clog2(bcrz_pkg::MAX_BUCKETS_DEF + 1),
  parameter int unsigned SW = CB + NW,
  parameter int unsigned QW = 2 * CB + NW
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start_i,
  input  logic [NW-1:0]     n_i,
  input  logic [SW-1:0]     s_i,
  input  logic [QW-1:0]     q_i,
  input  logic [CB-1:0]     c_i,
  output logic              done_o,
  output logic [31:0]       z_o
);

  localparam int unsigned DW    = NW + QW;
  localparam int unsigned RAW   = DW + 32;
  localparam int unsigned RADW  = RAW + (RAW % 2);
  localparam int unsigned RW    = RADW / 2;
  localparam int unsigned MW    = NW + CB;
  localparam int unsigned DVW   = MW + 32;
  localparam int unsigned CW    = $clog2(DVW + 1);

  bcrz_pkg::bcrz_sc_st_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r;
  logic            done_r;

  logic [NW-1:0]   n_r, n_sh_r;
  logic [SW-1:0]   s_r, s_sh_r;
  logic [DW-1:0]   q_sh_r, s_add_r, nq_r, ss_r;
  logic [MW-1:0]   nc_r, mag_r;
  logic            neg_r;
  logic [RADW-1:0] rad_r;
  logic [RW+1:0]   srem_r;
  logic [RW-1:0]   root_r;
  logic [RW-1:0]   dvs_r, drem_r;
  logic [DVW-1:0]  dvd_r;
  logic [31:0]     z_r;

  logic [DW-1:0]   d_w;
  logic [MW-1:0]   s_ext;
  logic [RW+1:0]   srem_t, trial;
  logic [RW:0]     drem_t;
  logic            last_w;

  assign d_w    = nq_r - ss_r;
  assign s_ext  = MW'(s_r);
  assign srem_t = {srem_r[RW-1:0], rad_r[RADW-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  assign drem_t = {drem_r, dvd_r[DVW-1]};
  assign last_w = (state_r == bcrz_pkg::SC_DIV) && (cnt_r == CW'(DVW - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcrz_pkg::SC_IDLE: if (start_i) state_nxt = bcrz_pkg::SC_MUL;
      bcrz_pkg::SC_MUL:  if (cnt_r == CW'(SW - 1)) state_nxt = bcrz_pkg::SC_PREP;
      bcrz_pkg::SC_PREP: state_nxt = (d_w == '0) ? bcrz_pkg::SC_DIV : bcrz_pkg::SC_SQRT;
      bcrz_pkg::SC_SQRT: if (cnt_r == CW'(RW - 1)) state_nxt = bcrz_pkg::SC_DIV;
      bcrz_pkg::SC_DIV:  if (cnt_r == CW'(DVW - 1)) state_nxt = bcrz_pkg::SC_IDLE;
      default: state_nxt = bcrz_pkg::SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcrz_pkg::SC_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= last_w;
      if (state_nxt != state_r) begin
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      bcrz_pkg::SC_IDLE: begin
        n_r     <= n_i;
        n_sh_r  <= n_i;
        s_r     <= s_i;
        s_sh_r  <= s_i;
        q_sh_r  <= DW'(q_i);
        s_add_r <= DW'(s_i);
        nq_r    <= '0;
        ss_r    <= '0;
        nc_r    <= MW'(n_i * c_i);
      end
      bcrz_pkg::SC_MUL: begin
        if (n_sh_r[0]) nq_r <= nq_r + q_sh_r;
        if (s_sh_r[0]) ss_r <= ss_r + s_add_r;
        n_sh_r  <= n_sh_r >> 1;
        s_sh_r  <= s_sh_r >> 1;
        q_sh_r  <= q_sh_r << 1;
        s_add_r <= s_add_r << 1;
      end
      bcrz_pkg::SC_PREP: begin
        neg_r  <= nc_r < s_ext;
        mag_r  <= (nc_r < s_ext) ? s_ext - nc_r : nc_r - s_ext;
        rad_r  <= {RADW'(d_w) << 32};
        srem_r <= '0;
        root_r <= '0;
        drem_r <= '0;
        // flat variance: sigma is one, divide by n at 2^16 scale
        dvd_r  <= (nc_r < s_ext) ? DVW'(s_ext - nc_r) << 16 : DVW'(nc_r - s_ext) << 16;
        dvs_r  <= RW'(n_r);
      end
      bcrz_pkg::SC_SQRT: begin
        rad_r <= rad_r << 2;
        if (srem_t >= trial) begin
          srem_r <= srem_t - trial;
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          srem_r <= srem_t;
          root_r <= {root_r[RW-2:0], 1'b0};
        end
        if (cnt_r == CW'(RW - 1)) begin
          dvs_r <= (srem_t >= trial) ? {root_r[RW-2:0], 1'b1} : {root_r[RW-2:0], 1'b0};
          dvd_r <= DVW'(mag_r) << 32;
        end
      end
      bcrz_pkg::SC_DIV: begin
        if (drem_t >= {1'b0, dvs_r}) begin
          drem_r <= RW'(drem_t - {1'b0, dvs_r});
          dvd_r  <= {dvd_r[DVW-2:0], 1'b1};
        end else begin
          drem_r <= drem_t[RW-1:0];
          dvd_r  <= {dvd_r[DVW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (done_r) begin
      if (neg_r) begin
        z_r <= (dvd_r[DVW-1:31] != '0) ? bcrz_pkg::Z_MIN : 32'd0 - dvd_r[31:0];
      end else begin
        z_r <= (dvd_r[DVW-1:31] != '0) ? bcrz_pkg::Z_MAX : dvd_r[31:0];
      end
    end
  end

  logic fin_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_r <= 1'b0;
    end else begin
      fin_r <= done_r;
    end
  end

  assign done_o = fin_r;
  assign z_o    = z_r;

endmodule

// ===== src/bucketed_cancel_rate_zscore.sv =====
// From accept to out_tvalid: new buckets are appended (up to MAX_BUCKETS); below two buckets
// the walk is skipped, else buckets are walked until an out-of-window bucket or the last filled
// bucket ends the walk; then both score units run side by side (no square root for a side with
// zero variance, no scoring with fewer than two buckets in the window).
// Throughput: one item in flight; the next is taken once the result sits in the output register.
// Reset (rst_n low, synchronous) empties the ring, clears held scores and restores registers.
module bucketed_cancel_rate_zscore #(
  parameter int unsigned MAX_BUCKETS = bcrz_pkg::MAX_BUCKETS_DEF,
  parameter int unsigned COUNT_BITS  = bcrz_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [63:0]                     in_tdata,   // event time in ns
  input  logic [2:0]                      in_tuser,   // is_delete, side[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [63:0]                     out_tdata,  // z_bid, z_ask
  output logic                            out_tuser,  // updated
  input  logic                            cfg_we,
  input  logic [bcrz_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcrz_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CB = COUNT_BITS;
  localparam int unsigned IW = $clog2(MAX_BUCKETS);
  localparam int unsigned FW = $clog2(MAX_BUCKETS + 1);
  localparam int unsigned SW = CB + FW;
  localparam int unsigned QW = 2 * CB + FW;
  localparam int unsigned EW = 64 + 2 * CB;

  bcrz_pkg::bcrz_st_t state_r, state_nxt;

  logic [31:0]   blen_r;
  logic [39:0]   wlen_r;
  logic [IW-1:0] head_r;
  logic [FW-1:0] filled_r, k_r, i_r, n_r;
  logic [63:0]   hstart_r, base_r, diff_r, cutoff_r;
  logic [CB-1:0] hbid_r, hask_r, b_r, a_r;
  logic [64:0]   acc_r;
  logic          del_r;
  logic [1:0]    side_r;
  logic [SW-1:0] sb_r, sa_r;
  logic [QW-1:0] qb_r, qa_r;
  logic [2*CB-1:0] sqb_r, sqa_r;
  logic [31:0]   zb_r, za_r;
  logic          upd_r, dn_b_r, dn_a_r;
  logic          ov_r;
  logic [63:0]   od_r;
  logic          ou_r;

  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra, head_inc;
  logic [EW-1:0] mem_wd, mem_rd;
  logic          acc_in;
  logic [63:0]   in_now, in_diff;
  logic [31:0]   len_w;
  logic [64:0]   acc_nxt;
  logic [CB-1:0] nbid, nask;
  logic [FW:0]   ra_t;
  logic          stale;
  logic          sc_start, dn_b, dn_a;
  logic [31:0]   zb_w, za_w;

  assign in_tready = (state_r == bcrz_pkg::ST_IDLE);
  assign acc_in    = in_tvalid && in_tready;
  assign in_now    = in_tdata;
  assign in_diff   = in_now - hstart_r;
  assign len_w     = (blen_r == '0) ? 32'd1 : blen_r;
  assign acc_nxt   = acc_r + 65'(len_w);
  assign head_inc  = (head_r == IW'(MAX_BUCKETS - 1)) ? '0 : head_r + 1'b1;
  assign nbid = (del_r && side_r == bcrz_pkg::SIDE_BID && !(&hbid_r)) ? hbid_r + 1'b1 : hbid_r;
  assign nask = (del_r && side_r == bcrz_pkg::SIDE_ASK && !(&hask_r)) ? hask_r + 1'b1 : hask_r;
  assign ra_t = {1'b0, FW'(head_r)} + ((FW'(head_r) < i_r) ? (FW+1)'(MAX_BUCKETS) : '0)
                - {1'b0, i_r};
  assign stale = mem_rd[63:0] < cutoff_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcrz_pkg::ST_IDLE: begin
        if (acc_in) begin
          if (filled_r != '0 && in_now >= hstart_r && in_diff >= 64'(len_w)) begin
            state_nxt = bcrz_pkg::ST_APPEND;
          end else begin
            state_nxt = bcrz_pkg::ST_COUNT;
          end
        end
      end
      bcrz_pkg::ST_APPEND: begin
        if (acc_nxt > {1'b0, diff_r} || k_r == FW'(MAX_BUCKETS)) begin
          state_nxt = bcrz_pkg::ST_COUNT;
        end
      end
      bcrz_pkg::ST_COUNT: begin
        state_nxt = (filled_r < FW'(2)) ? bcrz_pkg::ST_OUT : bcrz_pkg::ST_WREQ;
      end
      bcrz_pkg::ST_WREQ:  state_nxt = bcrz_pkg::ST_WDATA;
      bcrz_pkg::ST_WDATA: state_nxt = stale ? bcrz_pkg::ST_WEND : bcrz_pkg::ST_WACC;
      bcrz_pkg::ST_WACC: begin
        state_nxt = (i_r + 1'b1 == filled_r) ? bcrz_pkg::ST_WEND : bcrz_pkg::ST_WREQ;
      end
      bcrz_pkg::ST_WEND: begin
        state_nxt = (n_r < FW'(2)) ? bcrz_pkg::ST_OUT : bcrz_pkg::ST_SCORE;
      end
      bcrz_pkg::ST_SCORE: begin
        if ((dn_b_r || dn_b) && (dn_a_r || dn_a)) state_nxt = bcrz_pkg::ST_OUT;
      end
      bcrz_pkg::ST_OUT: begin
        if (!ov_r || out_tready) state_nxt = bcrz_pkg::ST_IDLE;
      end
      default: state_nxt = bcrz_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    sc_start = (state_r == bcrz_pkg::ST_WEND) && (n_r >= FW'(2));
    mem_we = 1'b0;
    mem_wa = head_r;
    mem_wd = {hask_r, hbid_r, hstart_r};
    mem_ra = ra_t[IW-1:0];
    unique case (state_r)
      bcrz_pkg::ST_IDLE: begin
        if (acc_in && filled_r == '0) begin
          mem_we = 1'b1;
          mem_wa = '0;
          mem_wd = {{(2*CB){1'b0}}, in_now};
        end
      end
      bcrz_pkg::ST_APPEND: begin
        mem_we = 1'b1;
        mem_wa = head_inc;
        mem_wd = {{(2*CB){1'b0}}, base_r + acc_r[63:0]};
      end
      bcrz_pkg::ST_COUNT: begin
        mem_we = 1'b1;
        mem_wd = {nask, nbid, hstart_r};
      end
      default: ;
    endcase
  end

  bcrz_mem #(
    .DEPTH(MAX_BUCKETS),
    .WIDTH(EW),
    .AW   (IW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_wa),
    .wdata(mem_wd),
    .raddr(mem_ra),
    .rdata(mem_rd)
  );

  bcrz_score #(.CB(CB), .NW(FW), .SW(SW), .QW(QW)) u_score_bid (
    .clk(clk), .rst_n(rst_n), .start_i(sc_start), .n_i(n_r), .s_i(sb_r), .q_i(qb_r),
    .c_i(hbid_r), .done_o(dn_b), .z_o(zb_w)
  );

  bcrz_score #(.CB(CB), .NW(FW), .SW(SW), .QW(QW)) u_score_ask (
    .clk(clk), .rst_n(rst_n), .start_i(sc_start), .n_i(n_r), .s_i(sa_r), .q_i(qa_r),
    .c_i(hask_r), .done_o(dn_a), .z_o(za_w)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bcrz_pkg::ST_IDLE;
      blen_r   <= bcrz_pkg::BUCKET_LEN_RST;
      wlen_r   <= bcrz_pkg::WINDOW_LEN_RST;
      head_r   <= '0;
      filled_r <= '0;
      zb_r     <= '0;
      za_r     <= '0;
      dn_b_r   <= 1'b0;
      dn_a_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (bcrz_pkg::bcrz_reg_t'(cfg_index))
          bcrz_pkg::REG_BUCKET_LEN: blen_r <= cfg_wdata[31:0];
          bcrz_pkg::REG_WINDOW_LEN: wlen_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == bcrz_pkg::ST_IDLE && acc_in && filled_r == '0) begin
        head_r   <= '0;
        filled_r <= FW'(1);
      end
      if (state_r == bcrz_pkg::ST_APPEND) begin
        head_r <= head_inc;
        if (filled_r != FW'(MAX_BUCKETS)) filled_r <= filled_r + 1'b1;
      end
      if (sc_start) begin
        dn_b_r <= 1'b0;
        dn_a_r <= 1'b0;
      end else begin
        if (dn_b) dn_b_r <= 1'b1;
        if (dn_a) dn_a_r <= 1'b1;
      end
      if (state_r == bcrz_pkg::ST_SCORE && state_nxt == bcrz_pkg::ST_OUT) begin
        zb_r <= zb_w;
        za_r <= za_w;
      end
      if (state_r == bcrz_pkg::ST_OUT && state_nxt == bcrz_pkg::ST_IDLE) begin
        ov_r <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      bcrz_pkg::ST_IDLE: begin
        if (acc_in) begin
          del_r  <= in_tuser[0];
          side_r <= in_tuser[2:1];
          diff_r <= in_diff;
          base_r <= hstart_r;
          acc_r  <= 65'(len_w);
          k_r    <= FW'(1);
          if (filled_r == '0) begin
            hstart_r <= in_now;
            hbid_r   <= '0;
            hask_r   <= '0;
          end
        end
      end
      bcrz_pkg::ST_APPEND: begin
        hstart_r <= base_r + acc_r[63:0];
        hbid_r   <= '0;
        hask_r   <= '0;
        acc_r    <= acc_nxt;
        k_r      <= k_r + 1'b1;
      end
      bcrz_pkg::ST_COUNT: begin
        hbid_r   <= nbid;
        hask_r   <= nask;
        cutoff_r <= (hstart_r >= 64'(wlen_r)) ? hstart_r - 64'(wlen_r) : '0;
        i_r      <= '0;
        n_r      <= '0;
        sb_r     <= '0;
        sa_r     <= '0;
        qb_r     <= '0;
        qa_r     <= '0;
        upd_r    <= 1'b0;
      end
      bcrz_pkg::ST_WDATA: begin
        b_r   <= mem_rd[64 +: CB];
        a_r   <= mem_rd[64 + CB +: CB];
        sqb_r <= mem_rd[64 +: CB] * mem_rd[64 +: CB];
        sqa_r <= mem_rd[64 + CB +: CB] * mem_rd[64 + CB +: CB];
      end
      bcrz_pkg::ST_WACC: begin
        sb_r <= sb_r + SW'(b_r);
        sa_r <= sa_r + SW'(a_r);
        qb_r <= qb_r + QW'(sqb_r);
        qa_r <= qa_r + QW'(sqa_r);
        n_r  <= n_r + 1'b1;
        i_r  <= i_r + 1'b1;
      end
      bcrz_pkg::ST_SCORE: begin
        upd_r <= 1'b1;
      end
      bcrz_pkg::ST_OUT: begin
        if (!ov_r || out_tready) begin
          od_r <= {za_r, zb_r};
          ou_r <= upd_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule
